### rtl/dip_pkg.sv
// Shared types and constants for the dual incremental PID block.
// Used by dip_lane and dual_incremental_pid; depends on nothing else.
`timescale 1ns / 1ps

package dip_pkg;

  localparam int SAMPLE_W = 16;          // setpoints and samples
  localparam int GAIN_W   = 32;          // Q16.16 gains
  localparam int DRIVE_W  = 16;          // Q2.14 drives
  localparam int ERR_W    = 17;          // setpoint minus sample
  localparam int DIFF_W   = 18;          // first difference and pair sum
  localparam int DIFF2_W  = 19;          // second difference
  localparam int PROD_W   = GAIN_W + DIFF2_W;
  localparam int ACC_W    = PROD_W + 3;
  localparam int CLAMP_W  = 18;          // holds -65536..65536
  localparam int ONE_Q16  = 65536;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = GAIN_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DIST_SETPOINT  = 3'd0,
    REG_ANGLE_SETPOINT = 3'd1,
    REG_DIST_KP        = 3'd2,
    REG_DIST_KI        = 3'd3,
    REG_DIST_KD        = 3'd4,
    REG_ANGLE_KP       = 3'd5,
    REG_ANGLE_KI       = 3'd6,
    REG_ANGLE_KD       = 3'd7
  } cfg_reg_t;

  // Settings of one loop.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] setpoint;
    logic signed [GAIN_W-1:0]   kp;
    logic signed [GAIN_W-1:0]   ki;
    logic signed [GAIN_W-1:0]   kd;
  } loop_cfg_t;

  // Stage load strobes that keep both lanes in step.
  typedef struct packed {
    logic load_diff;
    logic load_prod;
    logic load_sum;
    logic fire;
  } lane_ctrl_t;

endpackage

### rtl/dip_lane.sv
// One velocity-form PID loop: difference, multiply, sum and final stages.
// Depends on dip_pkg for widths and the loop_cfg_t and lane_ctrl_t types.
`timescale 1ns / 1ps

module dip_lane (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dip_pkg::loop_cfg_t                   cfg,
  input  dip_pkg::lane_ctrl_t                  ctrl,
  input  logic signed [dip_pkg::SAMPLE_W-1:0]  sample,
  output logic signed [dip_pkg::DRIVE_W-1:0]   drive
);
  import dip_pkg::*;

  localparam logic signed [ACC_W-1:0] POS_ONE = ACC_W'(ONE_Q16);
  localparam logic signed [ACC_W-1:0] NEG_ONE = -ACC_W'(ONE_Q16);

  logic signed [ERR_W-1:0]   err_last;
  logic signed [ERR_W-1:0]   err_before;
  logic signed [DRIVE_W-1:0] drive_last;

  logic signed [ERR_W-1:0]   err;
  logic signed [DIFF_W-1:0]  diff1_c;
  logic signed [DIFF_W-1:0]  pair_c;
  logic signed [DIFF2_W-1:0] diff2_c;

  logic signed [DIFF_W-1:0]  diff1;
  logic signed [DIFF_W-1:0]  pair;
  logic signed [DIFF2_W-1:0] diff2;

  logic signed [PROD_W-1:0]  prod_p;
  logic signed [PROD_W-1:0]  prod_i;
  logic signed [PROD_W-1:0]  prod_d;

  logic signed [ACC_W-1:0]   sum;
  logic signed [ACC_W-1:0]   acc;
  logic signed [CLAMP_W-1:0] clamped;
  logic signed [CLAMP_W:0]   rounded;

  always_comb begin
    err     = ERR_W'(cfg.setpoint) - ERR_W'(sample);
    diff1_c = DIFF_W'(err) - DIFF_W'(err_last);
    pair_c  = DIFF_W'(err) + DIFF_W'(err_last);
    diff2_c = DIFF2_W'(err) - (DIFF2_W'(err_last) <<< 1) + DIFF2_W'(err_before);
  end

  // Past errors advance when a request enters; the drive history advances
  // only when a result leaves, which keeps the feedback in request order.
  always_ff @(posedge clk) begin
    if (rst) begin
      err_last   <= '0;
      err_before <= '0;
      drive_last <= '0;
    end else begin
      if (ctrl.load_diff) begin
        err_before <= err_last;
        err_last   <= err;
      end
      if (ctrl.fire) begin
        drive_last <= drive;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_diff) begin
      diff1 <= diff1_c;
      pair  <= pair_c;
      diff2 <= diff2_c;
    end
    if (ctrl.load_prod) begin
      prod_p <= PROD_W'(cfg.kp) * PROD_W'(diff1);
      prod_i <= PROD_W'(cfg.ki) * PROD_W'(pair);
      prod_d <= PROD_W'(cfg.kd) * PROD_W'(diff2);
    end
    if (ctrl.load_sum) begin
      sum <= ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
    end
  end

  // Add the previous drive in Q.16, clamp to one, then round half up to Q2.14.
  always_comb begin
    acc = sum + (ACC_W'(drive_last) <<< 2);
    if (acc > POS_ONE) begin
      clamped = CLAMP_W'(ONE_Q16);
    end else if (acc < NEG_ONE) begin
      clamped = -CLAMP_W'(ONE_Q16);
    end else begin
      clamped = acc[CLAMP_W-1:0];
    end
    rounded = ((CLAMP_W+1)'(clamped) + (CLAMP_W+1)'(2)) >>> 2;
    drive   = rounded[DRIVE_W-1:0];
  end

endmodule

### rtl/dual_incremental_pid.sv
// Top level of the dual incremental PID block: settings, flow control, output.
// Depends on dip_pkg and instantiates two dip_lane loops.
`timescale 1ns / 1ps

// Two velocity-form PID loops, distance and angle, run side by side on each
// request and their drives leave together as one result. The block takes one
// request per clock while in_stall is low; an accepted request loads the
// difference stage on the edge that accepts it, then moves through multiply,
// sum, and the drive feedback stage that loads the output register. The
// feedback of the previous drive sets the throughput, and the three multipliers
// per loop (32x18, 32x18 and 32x19) set the depth.
// While the output is stalled, up to three more requests are still taken.
// Settings written on the cfg port apply to requests accepted afterwards and
// must only change while nothing is in flight.
module dual_incremental_pid (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [dip_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [dip_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [dip_pkg::SAMPLE_W-1:0]    dist_sample,
  input  logic signed [dip_pkg::SAMPLE_W-1:0]    angle_sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [dip_pkg::DRIVE_W-1:0]     dist_drive,
  output logic signed [dip_pkg::DRIVE_W-1:0]     angle_drive
);
  import dip_pkg::*;

  loop_cfg_t  dist_cfg;
  loop_cfg_t  angle_cfg;
  lane_ctrl_t ctrl;

  logic diff_valid;
  logic prod_valid;
  logic sum_valid;
  logic out_free;
  logic sum_ready;
  logic prod_ready;
  logic diff_ready;

  logic signed [DRIVE_W-1:0] dist_result;
  logic signed [DRIVE_W-1:0] angle_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_cfg  <= '0;
      angle_cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DIST_SETPOINT:  dist_cfg.setpoint  <= cfg_data[SAMPLE_W-1:0];
        REG_ANGLE_SETPOINT: angle_cfg.setpoint <= cfg_data[SAMPLE_W-1:0];
        REG_DIST_KP:        dist_cfg.kp        <= cfg_data;
        REG_DIST_KI:        dist_cfg.ki        <= cfg_data;
        REG_DIST_KD:        dist_cfg.kd        <= cfg_data;
        REG_ANGLE_KP:       angle_cfg.kp       <= cfg_data;
        REG_ANGLE_KI:       angle_cfg.ki       <= cfg_data;
        REG_ANGLE_KD:       angle_cfg.kd       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Each stage moves on when the one after it is empty or moving, so
  // bubbles close up while the output waits.
  always_comb begin
    out_free   = !out_valid || !out_stall;
    sum_ready  = !sum_valid || out_free;
    prod_ready = !prod_valid || sum_ready;
    diff_ready = !diff_valid || prod_ready;
    in_stall   = !diff_ready;

    ctrl.load_diff = in_valid && diff_ready;
    ctrl.load_prod = diff_valid && prod_ready;
    ctrl.load_sum  = prod_valid && sum_ready;
    ctrl.fire      = sum_valid && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid <= 1'b0;
      prod_valid <= 1'b0;
      sum_valid  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (diff_ready) begin
        diff_valid <= in_valid;
      end
      if (prod_ready) begin
        prod_valid <= diff_valid;
      end
      if (sum_ready) begin
        sum_valid <= prod_valid;
      end
      if (out_free) begin
        out_valid <= sum_valid;
      end
    end
  end

  dip_lane u_dist_lane (
    .clk    (clk),
    .rst    (rst),
    .cfg    (dist_cfg),
    .ctrl   (ctrl),
    .sample (dist_sample),
    .drive  (dist_result)
  );

  dip_lane u_angle_lane (
    .clk    (clk),
    .rst    (rst),
    .cfg    (angle_cfg),
    .ctrl   (ctrl),
    .sample (angle_sample),
    .drive  (angle_result)
  );

  // Both lanes finish in the same cycle; their drives form one result.
  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      dist_drive  <= dist_result;
      angle_drive <= angle_result;
    end
  end

endmodule

### sim/tb_dual_incremental_pid.sv
// Testbench for dual_incremental_pid: directed and random control ticks under
// varied flow control, checked against an in-bench model of both PID loops.
// Depends on dip_pkg and the dual_incremental_pid RTL.
`timescale 1ns / 1ps

module tb_dual_incremental_pid;
  import dip_pkg::*;

  localparam int LOOP_DIST    = 0;
  localparam int LOOP_ANGLE   = 1;
  localparam int DRAIN_CYCLES = 12;
  localparam int TIMEOUT_NS   = 2_000_000;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] dist_drv;
    logic signed [DRIVE_W-1:0] angle_drv;
  } drive_pair_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0]     cfg_index = REG_DIST_SETPOINT;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] dist_sample = '0;
  logic signed [SAMPLE_W-1:0] angle_sample = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [DRIVE_W-1:0]  dist_drive;
  logic signed [DRIVE_W-1:0]  angle_drive;

  // Model of both loops: settings and the state carried between ticks.
  longint loop_setpoint[2];
  longint loop_kp[2];
  longint loop_ki[2];
  longint loop_kd[2];
  longint loop_err_last[2];
  longint loop_err_before[2];
  longint loop_drive_last[2];
  longint walk_pos[2];

  drive_pair_t drives_due[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int failures       = 0;
  int requests_sent  = 0;
  int drives_checked = 0;
  int settings_loads = 0;

  dual_incremental_pid i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .dist_sample  (dist_sample),
    .angle_sample (angle_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .dist_drive   (dist_drive),
    .angle_drive  (angle_drive)
  );

  always #5 clk = ~clk;

  initial begin
    for (int lp = 0; lp < 2; lp++) begin
      loop_setpoint[lp]   = 0;
      loop_kp[lp]         = 0;
      loop_ki[lp]         = 0;
      loop_kd[lp]         = 0;
      loop_err_last[lp]   = 0;
      loop_err_before[lp] = 0;
      loop_drive_last[lp] = 0;
      walk_pos[lp]        = 0;
    end
  end

  // One velocity-form PID tick of one loop; returns the new Q2.14 drive.
  function automatic logic signed [DRIVE_W-1:0] step_pid_loop(
    int lp, logic signed [SAMPLE_W-1:0] sample);
    longint e;
    longint d1;
    longint s;
    longint d2;
    longint acc;
    longint drive;
    e   = loop_setpoint[lp];
    e   = e - sample;
    d1  = e - loop_err_last[lp];
    s   = e + loop_err_last[lp];
    d2  = e - 2 * loop_err_last[lp] + loop_err_before[lp];
    acc = loop_drive_last[lp] * 4 + loop_kp[lp] * d1 + loop_ki[lp] * s
          + loop_kd[lp] * d2;
    if (acc > ONE_Q16) acc = ONE_Q16;
    if (acc < -ONE_Q16) acc = -ONE_Q16;
    // Arithmetic shift floors, so adding half an LSB rounds half up.
    drive = (acc + 2) >>> 2;
    loop_err_before[lp] = loop_err_last[lp];
    loop_err_last[lp]   = e;
    loop_drive_last[lp] = drive;
    return drive[DRIVE_W-1:0];
  endfunction

  function automatic void apply_setting(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_DIST_SETPOINT:  loop_setpoint[LOOP_DIST]  = $signed(data[SAMPLE_W-1:0]);
      REG_ANGLE_SETPOINT: loop_setpoint[LOOP_ANGLE] = $signed(data[SAMPLE_W-1:0]);
      REG_DIST_KP:        loop_kp[LOOP_DIST]        = $signed(data);
      REG_DIST_KI:        loop_ki[LOOP_DIST]        = $signed(data);
      REG_DIST_KD:        loop_kd[LOOP_DIST]        = $signed(data);
      REG_ANGLE_KP:       loop_kp[LOOP_ANGLE]       = $signed(data);
      REG_ANGLE_KI:       loop_ki[LOOP_ANGLE]       = $signed(data);
      REG_ANGLE_KD:       loop_kd[LOOP_ANGLE]       = $signed(data);
      default: ;
    endcase
  endfunction

  // Leaves cfg_write high so that back-to-back writes need no toggle.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_setting(idx, data);
  endtask

  task automatic program_settings(
    logic [CFG_DATA_W-1:0] dist_sp, logic [CFG_DATA_W-1:0] angle_sp,
    logic [CFG_DATA_W-1:0] dist_kp, logic [CFG_DATA_W-1:0] dist_ki,
    logic [CFG_DATA_W-1:0] dist_kd, logic [CFG_DATA_W-1:0] angle_kp,
    logic [CFG_DATA_W-1:0] angle_ki, logic [CFG_DATA_W-1:0] angle_kd);
    write_reg(REG_DIST_SETPOINT, dist_sp);
    write_reg(REG_ANGLE_SETPOINT, angle_sp);
    write_reg(REG_DIST_KP, dist_kp);
    write_reg(REG_DIST_KI, dist_ki);
    write_reg(REG_DIST_KD, dist_kd);
    write_reg(REG_ANGLE_KP, angle_kp);
    write_reg(REG_ANGLE_KI, angle_ki);
    write_reg(REG_ANGLE_KD, angle_kd);
    cfg_write <= 1'b0;
    settings_loads++;
  endtask

  // Sends one request; valid stays high afterwards so the next one can follow.
  task automatic send_request(logic signed [SAMPLE_W-1:0] dist_s,
                              logic signed [SAMPLE_W-1:0] angle_s);
    drive_pair_t pair;
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    dist_sample  <= dist_s;
    angle_sample <= angle_s;
    do @(posedge clk); while (in_stall !== 1'b0);
    pair.dist_drv  = step_pid_loop(LOOP_DIST, dist_s);
    pair.angle_drv = step_pid_loop(LOOP_ANGLE, angle_s);
    drives_due.push_back(pair);
    requests_sent++;
  endtask

  // Holds off new requests until every pending drive pair has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (drives_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      drives_checked++;
      if (drives_due.size() == 0) begin
        $error("drive pair with no request pending: dist_drive %0d angle_drive %0d",
               dist_drive, angle_drive);
        failures++;
      end else begin
        drive_pair_t want;
        want = drives_due.pop_front();
        if (dist_drive !== want.dist_drv) begin
          $error("dist_drive mismatch: expected %0d, actual %0d", want.dist_drv,
                 dist_drive);
          failures++;
        end
        if (angle_drive !== want.angle_drv) begin
          $error("angle_drive mismatch: expected %0d, actual %0d", want.angle_drv,
                 angle_drive);
          failures++;
        end
      end
    end
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99, 0) < recv_stall_pct);
  end

  function automatic logic [CFG_DATA_W-1:0] random_gain();
    int unsigned pick;
    int g;
    pick = $urandom_range(99, 0);
    if (pick < 55) begin
      g = $urandom_range(256, 0);
      return g - 128;
    end else if (pick < 75) begin
      g = $urandom_range(131072, 0);
      return g - 65536;
    end else if (pick < 90) begin
      return $urandom();
    end
    case ($urandom_range(2, 0))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return '0;
    endcase
  endfunction

  // The upper half is junk on purpose; only the low 16 bits set the target.
  function automatic logic [CFG_DATA_W-1:0] random_setpoint();
    logic [SAMPLE_W-1:0] sp;
    logic [CFG_DATA_W-SAMPLE_W-1:0] junk;
    sp   = ($urandom_range(3, 0) == 0) ? SAMPLE_W'($urandom())
                                       : SAMPLE_W'($urandom_range(2000, 0) - 1000);
    junk = (CFG_DATA_W-SAMPLE_W)'($urandom());
    return {junk, sp};
  endfunction

  // Random walk of a sample, with an occasional jump anywhere in range.
  function automatic logic signed [SAMPLE_W-1:0] walk_sample(int lp, int stride);
    logic [SAMPLE_W-1:0] raw;
    if ($urandom_range(9, 0) == 0) begin
      raw = SAMPLE_W'($urandom());
      walk_pos[lp] = $signed(raw);
    end else begin
      walk_pos[lp] += longint'($urandom_range(2 * stride, 0)) - stride;
      if (walk_pos[lp] > 32767) walk_pos[lp] = 32767;
      if (walk_pos[lp] < -32768) walk_pos[lp] = -32768;
    end
    return walk_pos[lp][SAMPLE_W-1:0];
  endfunction

  // Reset state and zero gains must give zero drive whatever the samples.
  task automatic test_after_reset();
    send_request(16'sh7FFF, -16'sh8000);
    send_request(-16'sh8000, 16'sh7FFF);
    wait_drained();
  endtask

  // Full-scale errors against extreme gains drive both loops into the clamp.
  task automatic test_saturation();
    program_settings(32'hFFFF_7FFF, 32'h0000_8000,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(-16'sh8000, 16'sh7FFF);
    send_request(-16'sh8000, 16'sh7FFF);
    send_request(16'sh7FFF, -16'sh8000);
    send_request(16'sh7FFF, -16'sh8000);
    send_request(16'sh0000, 16'sh0000);
    send_request(-16'sh0001, -16'sh0001);
    wait_drained();
  endtask

  // Tiny gains put the sum on quarter-LSB steps, so half-way rounding shows.
  task automatic test_rounding();
    program_settings(32'h0, 32'h0, 32'h1, 32'h0, 32'h0,
                     32'hFFFF_FFFF, 32'h1, 32'h1);
    send_request(16'sh0000, 16'sh0000);
    send_request(-16'sh0001, 16'sh0001);
    send_request(-16'sh0003, 16'sh0003);
    send_request(-16'sh0001, 16'sh0001);
    send_request(16'sh0001, -16'sh0001);
    send_request(16'sh0003, -16'sh0003);
    send_request(16'sh0002, -16'sh0002);
    send_request(16'sh0000, 16'sh0000);
    wait_drained();
  endtask

  // Integral term alone on distance, derivative term alone on angle.
  task automatic test_single_terms();
    program_settings(32'd100, -32'sd100, 32'h0, 32'd64, 32'h0,
                     32'h0, 32'h0, -32'sd64);
    send_request(16'sd100, -16'sd100);
    send_request(16'sd90, -16'sd90);
    send_request(16'sd120, -16'sd80);
    send_request(16'sd100, -16'sd100);
    send_request(16'sd50, -16'sd150);
    send_request(16'sd100, -16'sd100);
    wait_drained();
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct);
    int stride;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int seg = 0; seg < 2; seg++) begin
      wait_drained();
      program_settings(random_setpoint(), random_setpoint(),
                       random_gain(), random_gain(), random_gain(),
                       random_gain(), random_gain(), random_gain());
      case ($urandom_range(2, 0))
        0: stride = 4;
        1: stride = 64;
        default: stride = 1024;
      endcase
      walk_pos[LOOP_DIST]  = loop_setpoint[LOOP_DIST];
      walk_pos[LOOP_ANGLE] = loop_setpoint[LOOP_ANGLE];
      for (int n = 0; n < 50; n++)
        send_request(walk_sample(LOOP_DIST, stride), walk_sample(LOOP_ANGLE, stride));
    end
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_after_reset();
    test_saturation();
    test_rounding();
    test_single_terms();
    test_random_phase(0, 0);
    test_random_phase(69, 0);
    test_random_phase(0, 69);
    test_random_phase(15, 15);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    in_valid <= 1'b0;
    for (int n = 0; n < 2000 && drives_due.size() != 0; n++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (drives_due.size() != 0) begin
      $error("%0d drive pairs never arrived", drives_due.size());
      failures++;
    end
    $display("Run covered %0d requests, %0d drive pairs checked, %0d setting loads,",
             requests_sent, drives_checked, settings_loads);
    $display("with clamping, rounding, single terms and four flow-control patterns.");
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule
